[hw/rtl/smda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_pkg: shared types and constants
// Word formats, mode codes and controller/datapath command and status
// bundles for the signed multiply / divide / accumulate core.
// ----------------------------------------------------------------------------
package smda_pkg;

    localparam int OPND_W   = 16;
    localparam int RES_W    = 40;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int CLK_W    = 4;
    localparam int DIV_STEPS = OPND_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    // Operation codes held in the mode register
    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;
    localparam logic [1:0] MODE_MAC = 2'd2;

    // Cycle counts reported by the emulated unit
    localparam logic [CLK_W-1:0] CLOCKS_BASIC = 4'd10;
    localparam logic [CLK_W-1:0] CLOCKS_MAC   = 4'd12;

    typedef struct packed {
        logic [OPND_W-1:0] operand_a;
        logic [OPND_W-1:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic             overflow;
        logic [CLK_W-1:0] emulated_clocks;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mult;
        logic combine;
        logic div_step;
        logic fixup;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode_div;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/smda_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_ctrl: operation sequencer
// Accepts input words, steps the datapath through multiply and combine, or
// divide iterations and fixup, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module smda_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  smda_pkg::status_t  status,
    output smda_pkg::cmd_t     cmd
);

    typedef enum logic [5:0]
    {
        ST_IDLE    = 6'b000001,
        ST_MULT    = 6'b000010,
        ST_COMBINE = 6'b000100,
        ST_DIVIDE  = 6'b001000,
        ST_FIXUP   = 6'b010000,
        ST_FINISH  = 6'b100000
    } state_t;

    localparam logic [smda_pkg::STEP_W-1:0] LAST_STEP =
        smda_pkg::STEP_W'(smda_pkg::DIV_STEPS - 1);

    state_t                        state_reg;
    state_t                        state_next;
    logic [smda_pkg::STEP_W-1:0]   step_cnt_reg;
    logic [smda_pkg::STEP_W-1:0]   step_cnt_next;

    // Take a new word only while idle
    assign in_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = status.mode_div ? ST_DIVIDE : ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_COMBINE;
            end
            ST_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_DIVIDE:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FIXUP;
                end
            end
            ST_FIXUP:
            begin
                cmd.fixup  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The last divide iteration always leads to the fixup step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && step_cnt_reg == LAST_STEP) |=> (state_reg == ST_FIXUP))
        else $error("divider did not exit after the last iteration");
`endif

endmodule

[hw/rtl/smda_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smda_dp: arithmetic datapath
// Mode register, operand latches, multiplier, accumulator adder, restoring
// divider with floor correction, accumulator and output register.
// ----------------------------------------------------------------------------
module smda_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_data,
    input  smda_pkg::in_word_t   in_data,
    input  smda_pkg::cmd_t       cmd,
    output smda_pkg::status_t    status,
    output logic                 out_valid,
    input  logic                 out_stall,
    output smda_pkg::out_word_t  out_data
);

    localparam int W  = smda_pkg::OPND_W;
    localparam int RW = smda_pkg::RES_W;
    localparam int PW = smda_pkg::PROD_W;

    logic [1:0]          op_mode_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [PW-1:0]       prod_reg;
    logic [W-1:0]        dvd_reg;
    logic [W-1:0]        rem_reg;
    logic                neg_reg;
    logic [RW-1:0]       res_reg;
    logic                ovf_reg;
    logic [RW-1:0]       acc_reg;
    logic                out_valid_reg;
    smda_pkg::out_word_t out_data_reg;

    logic                mode_mac;
    logic [W-1:0]        a_mag;
    logic [W:0]          rem_shift;
    logic [W:0]          rem_diff;
    logic [RW:0]         mac_sum;
    logic [W-1:0]        quo_fix;
    logic [W-1:0]        rem_fix;
    logic [RW-1:0]       div_res;

    assign mode_mac        = op_mode_reg[1];
    assign status.mode_div = (op_mode_reg == smda_pkg::MODE_DIV);
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    // Dividend magnitude; the most negative value maps to itself as unsigned
    assign a_mag = in_data.operand_a[W-1] ? (~in_data.operand_a + 1'b1)
                                          : in_data.operand_a;

    // One restoring divide iteration
    assign rem_shift = {rem_reg, dvd_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};

    // Accumulate with one guard bit for overflow
    assign mac_sum = {acc_reg[RW-1], acc_reg}
                   + {{(RW + 1 - PW){prod_reg[PW-1]}}, prod_reg};

    // Floor correction of the magnitude quotient
    always_comb
    begin
        quo_fix = dvd_reg;
        rem_fix = rem_reg;
        if (neg_reg)
        begin
            if (rem_reg == '0)
            begin
                quo_fix = ~dvd_reg + 1'b1;
            end
            else
            begin
                quo_fix = ~dvd_reg;
                rem_fix = b_reg - rem_reg;
            end
        end
        if (b_reg == '0)
        begin
            div_res = '0;
        end
        else
        begin
            div_res = {{(RW - 2 * W){rem_fix[W-1]}}, rem_fix, quo_fix};
        end
    end

    // Mode register, accumulator and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg   <= smda_pkg::MODE_MUL;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                op_mode_reg <= cfg_data;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= res_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= in_data.operand_a;
            b_reg   <= in_data.operand_b;
            dvd_reg <= a_mag;
            rem_reg <= '0;
            neg_reg <= in_data.operand_a[W-1];
        end
        if (cmd.mult)
        begin
            prod_reg <= PW'($signed(a_reg)) * PW'($signed(b_reg));
        end
        if (cmd.div_step)
        begin
            if (!rem_diff[W])
            begin
                rem_reg <= rem_diff[W-1:0];
                dvd_reg <= {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[W-1:0];
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            end
        end
        if (cmd.combine)
        begin
            if (mode_mac)
            begin
                res_reg <= mac_sum[RW-1:0];
                ovf_reg <= mac_sum[RW] ^ mac_sum[RW-1];
            end
            else
            begin
                res_reg <= {{(RW - PW){prod_reg[PW-1]}}, prod_reg};
                ovf_reg <= 1'b0;
            end
        end
        if (cmd.fixup)
        begin
            res_reg <= div_res;
            ovf_reg <= 1'b0;
        end
        if (cmd.publish)
        begin
            out_data_reg.result_value    <= res_reg;
            out_data_reg.overflow        <= ovf_reg;
            out_data_reg.emulated_clocks <= mode_mac ? smda_pkg::CLOCKS_MAC
                                                     : smda_pkg::CLOCKS_BASIC;
        end
    end

`ifndef NO_ASSERTIONS
    // The accumulator always follows the word just published
    a_acc_track: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (acc_reg == out_data_reg.result_value))
        else $error("accumulator does not match published word");

    // Overflow is only flagged in accumulate mode
    a_ovf_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.overflow) |-> mode_mac)
        else $error("overflow flagged outside accumulate mode");

    // Never publish over a word that is still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten while stalled");
`endif

endmodule

[hw/rtl/signed_multiply_divide_accumulate_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_multiply_divide_accumulate_core: 16-bit multiply / divide / MAC
// Top level joining the sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one word of two
//   16-bit operands. Output channel out_valid / out_stall / out_data carries
//   the 40-bit result, the overflow flag and the emulated clock count.
//   cfg_we / cfg_data write the 2-bit mode register; write it only when idle.
// Operation:
//   Multiply and accumulate: a multiply step, then an add step.
//   Divide: 16 iterations of a restoring divider, then a floor correction.
//   A new word is taken only after the previous result has been handed
//   to the output register.
// Reset:
//   rst_n clears the mode to signed multiply, the accumulator to zero and
//   empties the output register.
// Stall:
//   A finished word waits in the output register; the next word is already
//   accepted and computed, and only its hand-off waits for the receiver.
// ----------------------------------------------------------------------------
module signed_multiply_divide_accumulate_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  smda_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output smda_pkg::out_word_t  out_data
);

    smda_pkg::cmd_t    cmd;
    smda_pkg::status_t status;

    // Sequencer
    smda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic
    smda_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[tb/sv/signed_multiply_divide_accumulate_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_multiply_divide_accumulate_core_tb: self-checking testbench
// Sends operand words in every mode and keeps a shadow mode register and
// accumulator. Each result word is predicted when its operand word is
// accepted, and checked in order against the core's output. Both channels
// idle and stall at random, and the receiver holds off for long stretches.
// A directed run covers the operand extremes and the divide corner cases.
// A long accumulate run drives the accumulator past both ends of its range.
// ----------------------------------------------------------------------------
module signed_multiply_divide_accumulate_core_tb;

    // Mode 3 is a second accumulate code
    localparam logic [1:0] MODE_MAC_ALT  = 2'd3;
    localparam longint     ACC_LIMIT     = 64'sh80_0000_0000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         QUIET_LIMIT   = 4000;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                cfg_we   = 1'b0;
    logic [1:0]          cfg_data = smda_pkg::MODE_MUL;
    logic                in_valid = 1'b0;
    logic                in_stall;
    smda_pkg::in_word_t  in_data  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    smda_pkg::out_word_t out_data;

    // Shadow state of the core
    logic [smda_pkg::RES_W-1:0] acc_shadow  = '0;
    logic [1:0]                 mode_shadow = smda_pkg::MODE_MUL;

    smda_pkg::out_word_t pending_results[$];
    int        mismatch_count = 0;
    int        overflow_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      hold_rx        = 1'b0;
    int        quiet_cycles   = 0;

    signed_multiply_divide_accumulate_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Compute the result word for one operand word and advance the shadow state
    function automatic smda_pkg::out_word_t compute_result(input smda_pkg::in_word_t w);
        smda_pkg::out_word_t r;
        longint    a;
        longint    b;
        longint    d;
        longint    q;
        longint    m;
        longint    sum;
        a = longint'($signed(w.operand_a));
        b = longint'($signed(w.operand_b));
        d = longint'(w.operand_b);
        r = '0;
        r.emulated_clocks = smda_pkg::CLOCKS_BASIC;
        if (mode_shadow == smda_pkg::MODE_MAC || mode_shadow == MODE_MAC_ALT)
        begin
            sum = longint'($signed(acc_shadow)) + a * b;
            r.overflow = (sum >= ACC_LIMIT || sum < -ACC_LIMIT);
            r.result_value = sum[smda_pkg::RES_W-1:0];
            r.emulated_clocks = smda_pkg::CLOCKS_MAC;
            if (r.overflow)
                overflow_count++;
        end
        else if (mode_shadow == smda_pkg::MODE_DIV)
        begin
            // Floor division; a zero divisor leaves the result at zero
            if (d != 0)
            begin
                q = a / d;
                m = a % d;
                if (m < 0)
                begin
                    q = q - 1;
                    m = m + d;
                end
                r.result_value = {8'h00, m[15:0], q[15:0]};
                if (m[15])
                    r.result_value[smda_pkg::RES_W-1:32] = 8'hFF;
            end
        end
        else
        begin
            sum = a * b;
            r.result_value = sum[smda_pkg::RES_W-1:0];
        end
        acc_shadow = r.result_value;
        return r;
    endfunction

    // Pick an operand, biased toward the extremes
    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one word after random idle cycles; hold it until accepted
    task automatic send_word(input logic [15:0] a, input logic [15:0] b);
        smda_pkg::in_word_t w;
        w.operand_a = a;
        w.operand_b = b;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(compute_result(w));
    endtask

    // Stop sending and wait until every result word is back
    task automatic wait_for_results(input int settle);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write the mode register once the core is idle
    task automatic set_mode(input logic [1:0] mode);
        wait_for_results(4);
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_shadow = mode;
    endtask

    // Hold the receiver off for a fixed number of cycles
    task automatic hold_receiver(input int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx <= 1'b0;
    endtask

    task automatic test_directed();
        // Multiply, mode from reset
        send_word(16'h0000, 16'h0000);
        send_word(16'h7FFF, 16'h7FFF);
        send_word(16'h8000, 16'h8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'hFFFF, 16'h0001);
        // Divide: zero divisor, most negative dividend, negative remainders
        set_mode(smda_pkg::MODE_DIV);
        send_word(16'h1234, 16'h0000);
        send_word(16'h8000, 16'h0001);
        send_word(16'h7FFF, 16'hFFFF);
        send_word(16'h8000, 16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'hFFFF, 16'h0003);
        send_word(16'h0005, 16'h8000);
        send_word(16'h8000, 16'h8000);
        send_word(16'h8001, 16'h0007);
        // Accumulate under both codes
        set_mode(smda_pkg::MODE_MAC);
        send_word(16'h7FFF, 16'h8000);
        send_word(16'h8000, 16'h8000);
        send_word(16'hFFFF, 16'hFFFF);
        set_mode(MODE_MAC_ALT);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h0000, 16'h0000);
    endtask

    task automatic test_random_modes(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            set_mode(2'($urandom_range(0, 3)));
            burst = $urandom_range(10, 40);
            repeat (burst) send_word(rand_operand(), rand_operand());
            sent += burst;
        end
    endtask

    task automatic test_backpressure();
        // Fill the core while the receiver is held off
        set_mode(smda_pkg::MODE_MUL);
        fork
            hold_receiver(120);
            repeat (12) send_word(rand_operand(), rand_operand());
        join
        wait_for_results(4);
        set_mode(smda_pkg::MODE_DIV);
        fork
            hold_receiver(150);
            repeat (10) send_word(rand_operand(), rand_operand());
        join
        wait_for_results(4);
    endtask

    task automatic test_mac_overflow();
        int          start_count;
        int          tries;
        logic [15:0] r;
        // Push the accumulator up past the positive limit
        set_mode(smda_pkg::MODE_MAC);
        start_count = overflow_count;
        tries = 0;
        while (overflow_count == start_count && tries < 700)
        begin
            r = 16'($urandom_range(0, 15));
            send_word(16'h8000 + r, 16'h8000 + 16'($urandom_range(0, 15)));
            tries++;
        end
        repeat (8) send_word(16'h8000, 16'h8000);
        // Drive it back down past the negative limit
        set_mode(MODE_MAC_ALT);
        repeat (30)
        begin
            r = 16'($urandom_range(0, 15));
            send_word(16'h8000 + r, 16'h7FFF - 16'($urandom_range(0, 15)));
        end
    endtask

    // Drive receiver stalls
    always @(posedge clk)
        out_stall <= hold_rx || ($urandom_range(0, 99) < recv_stall_pct);

    // Check each result word against the oldest prediction
    always @(posedge clk)
    begin : check_results
        smda_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result word: expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.result_value !== want.result_value)
                begin
                    mismatch_count++;
                    $display("%0t: result_value mismatch: expected %h, actual %h",
                             $time, want.result_value, out_data.result_value);
                end
                if (out_data.overflow !== want.overflow)
                begin
                    mismatch_count++;
                    $display("%0t: overflow mismatch: expected %b, actual %b",
                             $time, want.overflow, out_data.overflow);
                end
                if (out_data.emulated_clocks !== want.emulated_clocks)
                begin
                    mismatch_count++;
                    $display("%0t: emulated_clocks mismatch: expected %0d, actual %0d",
                             $time, want.emulated_clocks, out_data.emulated_clocks);
                end
            end
        end
    end

    // End the run when no word moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        send_idle_pct  = 18;
        recv_stall_pct = 59;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_modes(200);

        send_idle_pct  = 59;
        recv_stall_pct = 18;
        test_backpressure();
        test_random_modes(200);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_mac_overflow();
        test_random_modes(150);

        wait_for_results(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
